// ===== hdl/oahs_pkg.sv =====
// shared types and constants for the open addressing hash set
// no dependencies; imported by oahs_mix_unit and open_addressing_hash_set

package oahs_pkg;

    // request fields
    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_CONTAINS = 2'd1,
        OP_CLEAR    = 2'd2
    } opcode_t;

    typedef logic [15:0] key_t;
    typedef logic [9:0]  count_t;

    // result codes
    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_PRESENT = 3'd1,
        ST_FOUND   = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4,
        ST_REJECT  = 3'd5
    } status_t;

    // steps of the shared hash multiplier
    typedef enum logic [1:0] {
        MIX_A     = 2'd0,
        MIX_B     = 2'd1,
        MIX_RANGE = 2'd2
    } mix_sel_t;

    localparam logic [16:0] MIX_MUL_A = 17'h02C5B;
    localparam logic [16:0] MIX_MUL_B = 17'h09E37;

    localparam count_t LOAD_LIMIT_RESET = 10'd768;

endpackage

// ===== hdl/open_addressing_hash_set.sv =====
// open addressing hash set of 16-bit keys with linear probing
// depends on oahs_pkg and oahs_mix_unit
//
// usage:
//   request channel: in_valid / in_stall with opcode and key; a request is
//   taken when in_valid is high and in_stall is low. one request is worked at
//   a time and in_stall stays high until its result has been placed in the
//   output register.
//   result channel: out_valid / out_stall with status and entry_count; one
//   result per request, held while out_stall is high. a new request may be
//   taken while an earlier result still waits in the output register.
//   load_limit is written through cfg_wr_en / cfg_wr_data at any clock edge.
// steps from a request taken to out_valid:
//   insert / contains: S_HASH1, S_HASH2 and S_HASH3 on the shared hash
//   multiplier, then a read of the slot table and a compare for each probed
//   slot, then S_RESULT, which waits while an earlier result is stalled
//   zero key or unused opcode: straight to S_RESULT
//   clear: slots are written empty, one slot per cycle, then S_RESULT
// reset: after rst_n goes high the table is swept empty while in_stall is high.

module open_addressing_hash_set #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  oahs_pkg::opcode_t opcode,
    input  oahs_pkg::key_t    key,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output oahs_pkg::status_t status,
    output oahs_pkg::count_t  entry_count,
    // load limit register
    input  logic              cfg_wr_en,
    input  oahs_pkg::count_t  cfg_wr_data
);
    import oahs_pkg::*;

    localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_READ,
        S_CHECK,
        S_RESULT
    } state_t;

    // control and payload registers
    state_t  state_reg,       state_next;
    idx_t    clr_idx_reg,     clr_idx_next;
    logic    clr_reply_reg,   clr_reply_next;
    opcode_t op_reg,          op_next;
    key_t    key_reg,         key_next;
    key_t    h_reg,           h_next;
    idx_t    probe_idx_reg,   probe_idx_next;
    idx_t    probe_cnt_reg,   probe_cnt_next;
    count_t  stored_cnt_reg,  stored_cnt_next;
    count_t  load_limit_reg,  load_limit_next;
    status_t res_status_reg,  res_status_next;
    logic    out_valid_reg,   out_valid_next;
    status_t status_reg,      status_next;
    count_t  entry_count_reg, entry_count_next;

    // slot table
    key_t slot_mem [TABLE_SIZE];
    key_t rdata_reg;
    logic mem_we;
    idx_t mem_waddr;
    key_t mem_wdata;

    // shared hash unit
    mix_sel_t    mix_sel;
    logic [32:0] mix_product;

    logic slot_empty;
    logic slot_hit;
    logic pass_done;

    oahs_mix_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mix (
        .sel     (mix_sel),
        .h       (h_reg),
        .product (mix_product)
    );

    always_comb
    begin
        case (state_reg)
            S_HASH1: mix_sel = MIX_A;
            S_HASH2: mix_sel = MIX_B;
            default: mix_sel = MIX_RANGE;
        endcase
    end

    // probe compare against the registered slot read
    assign slot_empty = (rdata_reg == '0);
    assign slot_hit   = (rdata_reg == key_reg);
    assign pass_done  = (probe_cnt_reg == LAST_IDX);

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        clr_reply_next   = clr_reply_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        h_next           = h_reg;
        probe_idx_next   = probe_idx_reg;
        probe_cnt_next   = probe_cnt_reg;
        stored_cnt_next  = stored_cnt_reg;
        load_limit_next  = load_limit_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = clr_idx_reg;
        mem_wdata        = '0;

        // output register drains when taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // load limit write
        if (cfg_wr_en)
        begin
            load_limit_next = cfg_wr_data;
        end

        case (state_reg)
            // sweep one slot per cycle to empty
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = IDX_W'(clr_idx_reg + 1'b1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    res_status_next = ST_REJECT;
                    state_next      = clr_reply_reg ? S_RESULT : S_IDLE;
                end
            end

            // take a request
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = opcode;
                    key_next = key;
                    h_next   = key;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            stored_cnt_next = '0;
                            clr_idx_next    = '0;
                            clr_reply_next  = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        OP_INSERT, OP_CONTAINS:
                        begin
                            if (key == '0)
                            begin
                                res_status_next = ST_REJECT;
                                state_next      = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_HASH1;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_REJECT;
                            state_next      = S_RESULT;
                        end
                    endcase
                end
            end

            // hash mix steps
            S_HASH1:
            begin
                h_next     = mix_product[15:0];
                state_next = S_HASH2;
            end

            S_HASH2:
            begin
                h_next     = mix_product[15:0];
                state_next = S_HASH3;
            end

            // range reduction gives the home slot
            S_HASH3:
            begin
                probe_idx_next = mix_product[IDX_W+15:16];
                probe_cnt_next = '0;
                state_next     = S_READ;
            end

            // slot read in flight
            S_READ:
            begin
                state_next = S_CHECK;
            end

            // decide on the slot just read
            S_CHECK:
            begin
                if (slot_empty)
                begin
                    state_next = S_RESULT;
                    if (op_reg == OP_INSERT)
                    begin
                        if (stored_cnt_reg >= load_limit_reg)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = probe_idx_reg;
                            mem_wdata       = key_reg;
                            stored_cnt_next = 10'(stored_cnt_reg + 10'd1);
                            res_status_next = ST_NEW;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_MISSING;
                    end
                end
                else if (slot_hit)
                begin
                    state_next      = S_RESULT;
                    res_status_next = (op_reg == OP_INSERT) ? ST_PRESENT : ST_FOUND;
                end
                else if (pass_done)
                begin
                    state_next      = S_RESULT;
                    res_status_next = (op_reg == OP_INSERT) ? ST_FULL : ST_MISSING;
                end
                else
                begin
                    probe_idx_next = (probe_idx_reg == LAST_IDX) ? '0
                                   : IDX_W'(probe_idx_reg + 1'b1);
                    probe_cnt_next = IDX_W'(probe_cnt_reg + 1'b1);
                    state_next     = S_READ;
                end
            end

            // hand the result to the output register once it is free
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    entry_count_next = stored_cnt_reg;
                    clr_reply_next   = 1'b0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            clr_reply_reg   <= 1'b0;
            op_reg          <= OP_INSERT;
            key_reg         <= '0;
            h_reg           <= '0;
            probe_idx_reg   <= '0;
            probe_cnt_reg   <= '0;
            stored_cnt_reg  <= '0;
            load_limit_reg  <= LOAD_LIMIT_RESET;
            res_status_reg  <= ST_REJECT;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_REJECT;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            clr_reply_reg   <= clr_reply_next;
            op_reg          <= op_next;
            key_reg         <= key_next;
            h_reg           <= h_next;
            probe_idx_reg   <= probe_idx_next;
            probe_cnt_reg   <= probe_cnt_next;
            stored_cnt_reg  <= stored_cnt_next;
            load_limit_reg  <= load_limit_next;
            res_status_reg  <= res_status_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            entry_count_reg <= entry_count_next;
        end
    end

    // slot table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= slot_mem[probe_idx_reg];
    end

    // ports
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

// ===== hdl/oahs_mix_unit.sv =====
// shared multiplier of the key hash: one xor-shift plus one multiply per step
// depends on oahs_pkg

module oahs_mix_unit #(
    parameter int TABLE_SIZE = 1024
) (
    input  oahs_pkg::mix_sel_t sel,
    input  oahs_pkg::key_t     h,
    output logic [32:0]        product
);
    import oahs_pkg::*;

    // multiplier that maps a 16-bit hash onto 0 .. TABLE_SIZE-1
    localparam logic [16:0] RANGE_MUL = 17'(TABLE_SIZE);

    key_t        mul_a;
    logic [16:0] mul_b;

    // operand selection per step
    always_comb
    begin
        case (sel)
            MIX_A:
            begin
                mul_a = h ^ (h >> 8);
                mul_b = MIX_MUL_A;
            end
            MIX_B:
            begin
                mul_a = h ^ (h >> 7);
                mul_b = MIX_MUL_B;
            end
            MIX_RANGE:
            begin
                mul_a = h ^ (h >> 9);
                mul_b = RANGE_MUL;
            end
            default:
            begin
                mul_a = h;
                mul_b = '0;
            end
        endcase
    end

    // the one multiplier
    assign product = 33'(mul_a) * 33'(mul_b);

endmodule
